[rtl/core/flp_pkg.sv]
// ----------------------------------------------------------------------------
// flp_pkg
// Shared types, codes and constants for the free-list object pool.
// ----------------------------------------------------------------------------
package flp_pkg;

   localparam int POOL_SIZE = 16;
   localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int PTR_W     = $clog2(POOL_SIZE + 1);
   localparam int MODE_W    = 3;
   localparam int CNT_W     = 5;

   // link value that names no entry
   localparam logic [PTR_W-1:0] NONE_MARK = PTR_W'(POOL_SIZE);
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

   localparam logic [MODE_W-1:0] MODE_REINIT  = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_ALLOC   = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_RELEASE = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_CLEAR   = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_CSTART  = MODE_W'(4);
   localparam logic [MODE_W-1:0] MODE_CNEXT   = MODE_W'(5);

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic             result_valid;
      logic             release_miss;
   } rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic             reinit;
      logic [PTR_W-1:0] count;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [PTR_W-1:0] wr_link;
      logic             wr_use;
      logic [IDX_W-1:0] rd_addr;
   } cell_cmd_type;

   // read bus handed from cell to cell
   typedef struct packed {
      logic             in_use;
      logic [PTR_W-1:0] link;
   } cell_rd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SINGLE,
      S_REL_WALK,
      S_REL_PUSH,
      S_CLR_WALK
   } state_type;

   function automatic logic is_entry(input logic [PTR_W-1:0] p);
      return p < NONE_MARK;
   endfunction

endpackage

[rtl/core/flp_cell.sv]
// ----------------------------------------------------------------------------
// flp_cell
// One pool entry: its next link and in-use flag, on a daisy-chained read bus.
// ----------------------------------------------------------------------------
module flp_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [flp_pkg::IDX_W-1:0] cell_id,
   input  flp_pkg::cell_cmd_type cmd,
   input  flp_pkg::cell_rd_type  rd_in,
   output flp_pkg::cell_rd_type  rd_out
);
   import flp_pkg::*;

   logic [PTR_W-1:0] link_ff, link_in;
   logic             use_ff, use_in;
   logic [PTR_W-1:0] succ;
   logic [PTR_W-1:0] chain_link;

   assign succ = PTR_W'(cell_id) + PTR_W'(1);

   always_comb begin
      if (reset) begin
         chain_link = (succ < NONE_MARK) ? succ : NONE_MARK;
      end else begin
         chain_link = (succ < cmd.count) ? succ : NONE_MARK;
      end
   end

   always_comb begin
      link_in = link_ff;
      use_in  = use_ff;
      if (reset || cmd.reinit) begin
         link_in = chain_link;
         use_in  = 1'b0;
      end else if (cmd.wr_en && (cmd.wr_addr == cell_id)) begin
         link_in = cmd.wr_link;
         use_in  = cmd.wr_use;
      end
   end

   always_ff @(posedge clock) begin
      link_ff <= link_in;
      use_ff  <= use_in;
   end

   // pass the neighbour's beat on unless this cell is addressed
   always_comb begin
      if (cmd.rd_addr == cell_id) begin
         rd_out.in_use = use_ff;
         rd_out.link   = link_ff;
      end else begin
         rd_out = rd_in;
      end
   end

endmodule

[rtl/core/flp_ctrl.sv]
// ----------------------------------------------------------------------------
// flp_ctrl
// Sequencer: list heads, cursor, list walks and the response register.
// ----------------------------------------------------------------------------
module flp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  flp_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output flp_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [flp_pkg::CNT_W-1:0]    csr_wdata,
   output flp_pkg::cell_cmd_type        cmd,
   input  flp_pkg::cell_rd_type         rd_data
);
   import flp_pkg::*;

   state_type         state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [PTR_W-1:0]  active_head_ff, active_head_in;
   logic [PTR_W-1:0]  cursor_ff, cursor_in;
   logic [PTR_W-1:0]  walk_ff, walk_in;
   logic [PTR_W-1:0]  prev_ff, prev_in;
   logic [PTR_W-1:0]  steps_ff, steps_in;
   logic [CNT_W-1:0]  pool_count_ff, pool_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              rel_hit;
   logic              walk_end;
   logic              clr_more;
   logic [PTR_W-1:0]  sat_count;
   logic [PTR_W-1:0]  cnext_ptr;
   rsp_type           res;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rel_hit  = is_entry(walk_ff) && (walk_ff[IDX_W-1:0] == idx_ff) && rd_data.in_use;
   assign walk_end = !is_entry(walk_ff) || (steps_ff == PTR_W'(POOL_SIZE));
   assign clr_more = is_entry(walk_ff) && (steps_ff != PTR_W'(POOL_SIZE));
   assign cnext_ptr = is_entry(cursor_ff) ? rd_data.link : cursor_ff;

   always_comb begin
      if (pool_count_ff == '0) begin
         sat_count = PTR_W'(1);
      end else if (32'(pool_count_ff) > POOL_SIZE) begin
         sat_count = NONE_MARK;
      end else begin
         sat_count = PTR_W'(pool_count_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_RELEASE) begin
                  state_in = S_REL_WALK;
               end else if (req_data.mode == MODE_CLEAR) begin
                  state_in = S_CLR_WALK;
               end else begin
                  state_in = S_SINGLE;
               end
            end
         end
         S_SINGLE: begin
            if (out_free) state_in = S_IDLE;
         end
         S_REL_WALK: begin
            if (rel_hit) begin
               state_in = S_REL_PUSH;
            end else if (walk_end && out_free) begin
               state_in = S_IDLE;
            end
         end
         S_REL_PUSH: begin
            if (out_free) state_in = S_IDLE;
         end
         S_CLR_WALK: begin
            if (!clr_more && out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in        = mode_ff;
      idx_in         = idx_ff;
      free_head_in   = free_head_ff;
      active_head_in = active_head_ff;
      cursor_in      = cursor_ff;
      walk_in        = walk_ff;
      prev_in        = prev_ff;
      steps_in       = steps_ff;
      pool_count_in  = csr_we ? csr_wdata : pool_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      res            = '0;

      cmd         = '0;
      cmd.count   = sat_count;
      cmd.rd_addr = walk_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_data.mode;
               idx_in   = req_data.entry_index;
               walk_in  = active_head_ff;
               prev_in  = NONE_MARK;
               steps_in = '0;
               if (req_data.mode == MODE_CLEAR) cursor_in = active_head_ff;
            end
         end
         S_SINGLE: begin
            if (mode_ff == MODE_ALLOC) begin
               cmd.rd_addr = free_head_ff[IDX_W-1:0];
            end else begin
               cmd.rd_addr = cursor_ff[IDX_W-1:0];
            end
            if (out_free) begin
               case (mode_ff)
                  MODE_REINIT: begin
                     cmd.reinit     = 1'b1;
                     free_head_in   = '0;
                     active_head_in = NONE_MARK;
                     cursor_in      = NONE_MARK;
                  end
                  MODE_ALLOC: begin
                     if (is_entry(free_head_ff)) begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_addr      = free_head_ff[IDX_W-1:0];
                        cmd.wr_link      = active_head_ff;
                        cmd.wr_use       = 1'b1;
                        free_head_in     = rd_data.link;
                        active_head_in   = free_head_ff;
                        res.result_index = free_head_ff[IDX_W-1:0];
                        res.result_valid = 1'b1;
                     end
                  end
                  MODE_CSTART: begin
                     cursor_in = active_head_ff;
                     if (is_entry(active_head_ff)) begin
                        res.result_index = active_head_ff[IDX_W-1:0];
                        res.result_valid = 1'b1;
                     end
                  end
                  MODE_CNEXT: begin
                     if (is_entry(cnext_ptr)) begin
                        cursor_in        = cnext_ptr;
                        res.result_index = cnext_ptr[IDX_W-1:0];
                        res.result_valid = 1'b1;
                     end else begin
                        cursor_in = NONE_MARK;
                     end
                  end
                  default: ;
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
            end
         end
         S_REL_WALK: begin
            if (rel_hit) begin
               // unlink: predecessor (or head) takes the found entry's link
               if (is_entry(prev_ff)) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = prev_ff[IDX_W-1:0];
                  cmd.wr_link = rd_data.link;
                  cmd.wr_use  = 1'b1;
               end else begin
                  active_head_in = rd_data.link;
               end
            end else if (walk_end) begin
               if (out_free) begin
                  res.release_miss = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = res;
               end
            end else begin
               prev_in  = walk_ff;
               walk_in  = rd_data.link;
               steps_in = steps_ff + PTR_W'(1);
            end
         end
         S_REL_PUSH: begin
            if (out_free) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_addr  = idx_ff;
               cmd.wr_link  = free_head_ff;
               cmd.wr_use   = 1'b0;
               free_head_in = PTR_W'(idx_ff);
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
            end
         end
         S_CLR_WALK: begin
            if (clr_more) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_addr  = walk_ff[IDX_W-1:0];
               cmd.wr_link  = free_head_ff;
               cmd.wr_use   = 1'b0;
               free_head_in = walk_ff;
               walk_in      = rd_data.link;
               steps_in     = steps_ff + PTR_W'(1);
            end else if (out_free) begin
               active_head_in = NONE_MARK;
               rsp_valid_in   = 1'b1;
               rsp_data_in    = res;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         free_head_ff   <= '0;
         active_head_ff <= NONE_MARK;
         cursor_ff      <= NONE_MARK;
         pool_count_ff  <= COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_head_ff   <= free_head_in;
         active_head_ff <= active_head_in;
         cursor_ff      <= cursor_in;
         pool_count_ff  <= pool_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      walk_ff     <= walk_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/core/free_list_object_pool_top.sv]
// ----------------------------------------------------------------------------
// free_list_object_pool_top
// Pool of entries on a free list and an active list sharing one link table.
// ----------------------------------------------------------------------------
// Request beats (req_*) carry a mode and an entry index; each gives exactly
// one response beat (rsp_*) with result index, valid flag and miss flag.
// csr_we/csr_wdata set the entry count used by the next reinit.
// Requests are taken one at a time. Reinit, allocate and the cursor modes
// answer from the S_SINGLE state once the output register is free, and a
// further request is taken only after that. Release walks the active list
// one link per cycle from the head, then pushes the found entry onto the
// free list; a miss walks the full list before it answers.
// Clear moves one active entry to the free list per cycle.
// Each cycle is one read of the cell row, whose read bus is daisy-chained
// through all POOL_SIZE cells.
// A finished response sits in an output register; the next request is
// taken while it waits, and that request stalls at its final step until the
// register is free. Synchronous reset rebuilds the full free list and
// empties the active list; the count register resets to 16.
// ----------------------------------------------------------------------------
module free_list_object_pool_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  flp_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output flp_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [flp_pkg::CNT_W-1:0] csr_wdata
);
   import flp_pkg::*;

   cell_cmd_type cmd;
   cell_rd_type  rd_chain [POOL_SIZE+1];

   assign rd_chain[0].in_use = 1'b0;
   assign rd_chain[0].link   = NONE_MARK;

   flp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .rd_data   (rd_chain[POOL_SIZE])
   );

   for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
      flp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (IDX_W'(i)),
         .cmd     (cmd),
         .rd_in   (rd_chain[i]),
         .rd_out  (rd_chain[i+1])
      );
   end

endmodule

[bench/free_list_object_pool_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_object_pool_top_tb
// Self-checking bench for the free-list object pool: a shadow of the free
// list, active list and cursor predicts every response beat, which is checked
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module free_list_object_pool_top_tb;
   import flp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE6 = MODE_W'(6);
   localparam logic [MODE_W-1:0] MODE_SPARE7 = MODE_W'(7);
   localparam int LIMIT_CYCLES = 500000;
   localparam int DRAIN_CYCLES = 2 * POOL_SIZE + 8;
   localparam int IDLE_PCT     = 33;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   free_list_object_pool_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the pool
   logic [CNT_W-1:0] shadow_count;
   logic [PTR_W-1:0] free_head;
   logic [PTR_W-1:0] active_head;
   logic [PTR_W-1:0] cursor;
   logic [PTR_W-1:0] link_tbl [POOL_SIZE];

   req_type pending_q [$];
   rsp_type want_q [$];
   bit      no_gaps = 1'b0;
   int      errors = 0;
   int      n_beats = 0;
   int      n_alloc_empty = 0;
   int      n_rel_miss = 0;
   int      cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void rebuild_free_list(logic [CNT_W-1:0] count_in);
      int c;
      c = count_in;
      if (c < 1) c = 1;
      if (c > POOL_SIZE) c = POOL_SIZE;
      for (int i = 0; i < POOL_SIZE; i++)
         link_tbl[i] = (i + 1 < c) ? PTR_W'(i + 1) : NONE_MARK;
      free_head   = '0;
      active_head = NONE_MARK;
      cursor      = NONE_MARK;
   endfunction

   // applies one request to the shadow and returns the response it gives
   function automatic rsp_type pool_op(req_type r);
      rsp_type          o;
      logic [PTR_W-1:0] p;
      logic [PTR_W-1:0] prev;
      logic [PTR_W-1:0] nx;
      logic [PTR_W-1:0] target;
      int               steps;
      o      = '0;
      target = PTR_W'(r.entry_index);
      case (r.mode)
         MODE_REINIT: rebuild_free_list(shadow_count);
         MODE_ALLOC: begin
            p = free_head;
            if (p < NONE_MARK) begin
               free_head      = link_tbl[p];
               link_tbl[p]    = active_head;
               active_head    = p;
               o.result_index = p[IDX_W-1:0];
               o.result_valid = 1'b1;
            end
         end
         MODE_RELEASE: begin
            p     = active_head;
            prev  = NONE_MARK;
            steps = 0;
            while (p < NONE_MARK && p != target && steps < POOL_SIZE) begin
               prev = p;
               p    = link_tbl[p];
               steps++;
            end
            if (p < NONE_MARK && p == target) begin
               if (prev < NONE_MARK) link_tbl[prev] = link_tbl[p];
               else active_head = link_tbl[p];
               link_tbl[p] = free_head;
               free_head   = p;
            end else begin
               o.release_miss = 1'b1;
            end
         end
         MODE_CLEAR: begin
            // cursor keeps the old head, which ends up on the free list
            cursor = active_head;
            p      = active_head;
            steps  = 0;
            while (p < NONE_MARK && steps < POOL_SIZE) begin
               nx          = link_tbl[p];
               link_tbl[p] = free_head;
               free_head   = p;
               p           = nx;
               steps++;
            end
            active_head = NONE_MARK;
         end
         MODE_CSTART: begin
            cursor = active_head;
            if (cursor < NONE_MARK) begin
               o.result_index = cursor[IDX_W-1:0];
               o.result_valid = 1'b1;
            end
         end
         MODE_CNEXT: begin
            if (cursor < NONE_MARK) cursor = link_tbl[cursor];
            if (cursor < NONE_MARK) begin
               o.result_index = cursor[IDX_W-1:0];
               o.result_valid = 1'b1;
            end else begin
               cursor = NONE_MARK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // request driver: predicts on each accepted beat, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            want_q.push_back(pool_op(req_data));
            n_beats++;
            if (req_data.mode == MODE_ALLOC && !want_q[$].result_valid) n_alloc_empty++;
            if (want_q[$].release_miss) n_rel_miss++;
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= pending_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_mon
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (want_q.size() == 0) begin
               errors++;
               $error("response beat with nothing expected");
            end else begin
               want = want_q.pop_front();
               if (rsp_data.result_index !== want.result_index) begin
                  errors++;
                  $error("result_index: expected %0d, got %0d",
                         want.result_index, rsp_data.result_index);
               end
               if (rsp_data.result_valid !== want.result_valid) begin
                  errors++;
                  $error("result_valid: expected %0d, got %0d",
                         want.result_valid, rsp_data.result_valid);
               end
               if (rsp_data.release_miss !== want.release_miss) begin
                  errors++;
                  $error("release_miss: expected %0d, got %0d",
                         want.release_miss, rsp_data.release_miss);
               end
            end
         end
         rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic add_op(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx);
      req_type r;
      r.mode        = m;
      r.entry_index = idx;
      pending_q.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || want_q.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_count(logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we       <= 1'b0;
      shadow_count = v;
   endtask

   // mostly allocate/release traffic and cursor walks over the live entries
   task automatic add_random(int n, int alloc_pct, int span);
      int left;
      int pick;
      int k;
      left = n;
      while (left > 0) begin
         if ($urandom_range(99) < alloc_pct) begin
            add_op(MODE_ALLOC, IDX_W'($urandom_range(15)));
            left--;
         end else begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               add_op(MODE_RELEASE, ($urandom_range(3) != 0) ?
                      IDX_W'($urandom_range(span - 1)) : IDX_W'($urandom_range(15)));
               left--;
            end else if (pick < 78) begin
               // walk: start then steps; steps alone follow a stale cursor
               if ($urandom_range(9) >= 3) begin
                  add_op(MODE_CSTART, IDX_W'($urandom_range(15)));
                  left--;
               end
               k = $urandom_range(span + 1);
               repeat (k) add_op(MODE_CNEXT, IDX_W'($urandom_range(15)));
               left -= k;
            end else if (pick < 88) begin
               add_op(MODE_CLEAR, IDX_W'($urandom_range(15)));
               left--;
            end else if (pick < 95) begin
               add_op(MODE_REINIT, IDX_W'($urandom_range(15)));
               left--;
            end else begin
               add_op($urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7,
                      IDX_W'($urandom_range(15)));
               left--;
            end
         end
      end
   endtask

   initial begin
      int phase_cnt [7];
      int phase_alloc [7];
      int phase_items [7];
      int span;

      phase_cnt    = '{0, 16, 31, 5, 12, 16, 1};
      phase_alloc  = '{40, 60, 45, 40, 50, 35, 45};
      phase_items  = '{90, 200, 150, 150, 150, 150, 120};
      shadow_count = COUNT_RESET;
      rebuild_free_list(COUNT_RESET);
      phase_cnt[6] = $urandom_range(2, 15);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty active list, spare modes, unlink from middle and head,
      // stale cursor after release and after clear
      add_op(MODE_CNEXT,   4'd0);
      add_op(MODE_CSTART,  4'd0);
      add_op(MODE_RELEASE, 4'd15);
      add_op(MODE_CLEAR,   4'd0);
      add_op(MODE_SPARE6,  4'd15);
      add_op(MODE_SPARE7,  4'd0);
      add_op(MODE_ALLOC,   4'd0);
      add_op(MODE_ALLOC,   4'd0);
      add_op(MODE_ALLOC,   4'd15);
      add_op(MODE_CSTART,  4'd0);
      add_op(MODE_CNEXT,   4'd0);
      add_op(MODE_RELEASE, 4'd1);
      add_op(MODE_CNEXT,   4'd0);
      add_op(MODE_RELEASE, 4'd2);
      add_op(MODE_RELEASE, 4'd1);
      add_op(MODE_ALLOC,   4'd0);
      add_op(MODE_CLEAR,   4'd0);
      add_op(MODE_CNEXT,   4'd0);
      add_op(MODE_REINIT,  4'd0);
      wait_idle();

      // single-entry pool: exhaust the free list at once
      write_count(CNT_W'(1));
      add_op(MODE_REINIT,  4'd0);
      add_op(MODE_ALLOC,   4'd0);
      add_op(MODE_ALLOC,   4'd0);
      add_op(MODE_RELEASE, 4'd0);
      add_random(90, 40, 1);
      wait_idle();

      for (int p = 0; p < 7; p++) begin
         span = phase_cnt[p];
         if (span < 1) span = 1;
         if (span > POOL_SIZE) span = POOL_SIZE;
         write_count(CNT_W'(phase_cnt[p]));
         no_gaps = (p == 1);
         add_op(MODE_REINIT, IDX_W'($urandom_range(15)));
         add_random(phase_items[p], phase_alloc[p], span);
         wait_idle();
      end
      no_gaps = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d request beats over nine count settings between 0 and 31.",
               n_beats);
      $display("Allocations on an empty pool: %0d, release misses: %0d, errors: %0d.",
               n_alloc_empty, n_rel_miss, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
